// File: hdl/ksgoc_pkg.sv
// Shared types and constants for the keyed slot get-or-create block.
`default_nettype none

package ksgoc_pkg;

   localparam int KEY_W    = 32;
   localparam int INDEX_W  = 4;
   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] RSP_FOUND   = 2'd0;
   localparam logic [STATUS_W-1:0] RSP_CREATED = 2'd1;
   localparam logic [STATUS_W-1:0] RSP_FULL    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_SCAN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic start;
      logic advance;
      logic compare;
      logic commit;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic hit;
      logic last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// File: hdl/keyed_slot_get_or_create_top.sv
// Top level of the keyed slot get-or-create block: controller and datapath.
// A request beat is taken only in the idle state; the controller then primes the first key read,
// scans the slots in order until a match or the last slot, and waits for the output register.
// A stalled earlier result delays the hand-off. A new request is accepted only after the previous
// result is loaded, with one slot compared per cycle through the single read port of the key memory.
// Reset clears every valid mark at once; keys stay undefined until a slot is created.
`default_nettype none

module keyed_slot_get_or_create_top #(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [ksgoc_pkg::KEY_W-1:0]         req_lookup_key,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [ksgoc_pkg::INDEX_W-1:0]            rsp_slot_index,
   output logic [ksgoc_pkg::STATUS_W-1:0]           rsp_status
);
   import ksgoc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   ksgoc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ksgoc_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_lookup_key (req_lookup_key),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_slot_index (rsp_slot_index),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire

// File: hdl/ksgoc_ctrl.sv
// Controller state machine: sequences acceptance, table scan and result hand-off.
`default_nettype none

module ksgoc_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire ksgoc_pkg::dp_status_type status,
   output ksgoc_pkg::ctrl_cmd_type      cmd
);
   import ksgoc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_PRIME;
            end
         end
         ST_PRIME: begin
            // first key read is in flight
            cmd.advance = 1'b1;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.advance = 1'b1;
            cmd.compare = 1'b1;
            if (status.hit || status.last) begin
               cmd.commit = 1'b1;
               state_in   = ST_RESULT;
            end
         end
         ST_RESULT: begin
            // hold until the output register can take the beat
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   a_accept_primes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_PRIME))
      else $error("accepted beat did not start a scan");

   a_scan_continues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && !status.hit && !status.last) |=> (state_ff == ST_SCAN))
      else $error("scan left before a hit or the last slot");

   a_single_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> !cmd.commit)
      else $error("result committed twice for one request");

endmodule

`default_nettype wire

// File: hdl/ksgoc_dp.sv
// Datapath: key memory, valid marks, scan pointer, free-slot tracking and output register.
`default_nettype none

module ksgoc_dp #(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [ksgoc_pkg::KEY_W-1:0]         req_lookup_key,
   input  wire ksgoc_pkg::ctrl_cmd_type             cmd,
   output ksgoc_pkg::dp_status_type                 status,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [ksgoc_pkg::INDEX_W-1:0]            rsp_slot_index,
   output logic [ksgoc_pkg::STATUS_W-1:0]           rsp_status
);
   import ksgoc_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int EXT_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   logic [KEY_W-1:0]         slot_key_mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] slot_valid_ff, slot_valid_in;
   logic [KEY_W-1:0]         key_ff, key_in;
   logic [KEY_W-1:0]         rd_key_ff;
   logic [IDX_W-1:0]         rd_idx_ff;
   logic [IDX_W-1:0]         addr_ff, addr_in;
   logic                     free_found_ff, free_found_in;
   logic [IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]         res_idx_ff, res_idx_in;
   logic [STATUS_W-1:0]      res_status_ff, res_status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]       rsp_slot_index_ff, rsp_slot_index_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [EXT_W-1:0]         res_idx_ext;
   logic [IDX_W-1:0]         free_now;
   logic                     cur_free, hit, any_free, wr_en;

   assign cur_free = !slot_valid_ff[rd_idx_ff];
   assign hit      = slot_valid_ff[rd_idx_ff] && (rd_key_ff == key_ff);
   assign any_free = free_found_ff || cur_free;
   assign free_now = free_found_ff ? free_idx_ff : rd_idx_ff;
   assign wr_en    = cmd.commit && !hit && any_free;

   assign status.hit      = hit;
   assign status.last     = (rd_idx_ff == LAST_IDX);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign res_idx_ext = EXT_W'(res_idx_ff);

   always_comb begin
      key_in        = cmd.start ? req_lookup_key : key_ff;

      addr_in       = addr_ff;
      if (cmd.start) begin
         addr_in = '0;
      end else if (cmd.advance && (addr_ff != LAST_IDX)) begin
         addr_in = addr_ff + 1'b1;
      end

      // remember the lowest free slot seen so far
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      if (cmd.start) begin
         free_found_in = 1'b0;
      end else if (cmd.compare && !free_found_ff && cur_free) begin
         free_found_in = 1'b1;
         free_idx_in   = rd_idx_ff;
      end

      res_idx_in    = res_idx_ff;
      res_status_in = res_status_ff;
      if (cmd.commit) begin
         priority if (hit) begin
            res_idx_in    = rd_idx_ff;
            res_status_in = RSP_FOUND;
         end else if (any_free) begin
            res_idx_in    = free_now;
            res_status_in = RSP_CREATED;
         end else begin
            res_idx_in    = '0;
            res_status_in = RSP_FULL;
         end
      end

      slot_valid_in = slot_valid_ff;
      if (wr_en) begin
         slot_valid_in[free_now] = 1'b1;
      end

      rsp_slot_index_in = rsp_slot_index_ff;
      rsp_status_in     = rsp_status_ff;
      if (cmd.load_out) begin
         rsp_slot_index_in = res_idx_ext[INDEX_W-1:0];
         rsp_status_in     = res_status_ff;
         rsp_valid_in      = 1'b1;
      end else begin
         rsp_valid_in      = rsp_stall ? rsp_valid_ff : 1'b0;
      end
   end

   // key memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_key_mem[free_now] <= key_ff;
      end
      rd_key_ff <= slot_key_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         addr_ff       <= '0;
         rd_idx_ff     <= '0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         free_found_ff <= free_found_in;
         addr_ff       <= addr_in;
         rd_idx_ff     <= addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff            <= key_in;
      free_idx_ff       <= free_idx_in;
      res_idx_ff        <= res_idx_in;
      res_status_ff     <= res_status_in;
      rsp_slot_index_ff <= rsp_slot_index_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = rsp_slot_index_ff;
   assign rsp_status     = rsp_status_ff;

   a_create_marks_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> slot_valid_ff[$past(free_now)])
      else $error("created slot not marked valid");

   a_create_stores_key: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (slot_key_mem[$past(free_now)] == $past(key_ff)))
      else $error("created slot does not hold the request key");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output register overwritten while its beat was stalled");

endmodule

`default_nettype wire

// File: verif/keyed_slot_get_or_create_top_tb.sv
// Self-checking testbench for the keyed slot get-or-create top level.
`timescale 1ns / 100ps

module keyed_slot_get_or_create_top_tb;
   import ksgoc_pkg::*;

   localparam int TABLE_ENTRIES = 16;
   localparam int RANDOM_REQS   = 1030;
   localparam int MAX_GAP       = 19;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct packed {
      logic [INDEX_W-1:0]  slot_index;
      logic [STATUS_W-1:0] status;
   } slot_reply_type;

   // Mirrors the slot table and queues the reply each request beat must produce.
   class slot_lookup_board_type;
      bit                 slot_taken [TABLE_ENTRIES];
      logic [KEY_W-1:0]   slot_key   [TABLE_ENTRIES];
      slot_reply_type     pending_replies [$];
      int unsigned        mismatches;

      function new();
         foreach (slot_taken[i]) slot_taken[i] = 1'b0;
         mismatches = 0;
      endfunction

      function slot_reply_type resolve_key(logic [KEY_W-1:0] key);
         slot_reply_type reply;
         reply.slot_index = '0;
         reply.status     = RSP_FULL;
         // the whole table is searched before any slot is claimed
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_taken[i] && slot_key[i] == key) begin
               reply.slot_index = INDEX_W'(i);
               reply.status     = RSP_FOUND;
               return reply;
            end
         end
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!slot_taken[i]) begin
               slot_taken[i]    = 1'b1;
               slot_key[i]      = key;
               reply.slot_index = INDEX_W'(i);
               reply.status     = RSP_CREATED;
               return reply;
            end
         end
         return reply;
      endfunction

      function void take_request(logic [KEY_W-1:0] key);
         pending_replies.push_back(resolve_key(key));
      endfunction

      task report_mismatch(string what);
         $display("%0t mismatch: %s", $time, what);
         mismatches++;
      endtask

      task match_reply(logic [INDEX_W-1:0] idx, logic [STATUS_W-1:0] st);
         slot_reply_type want;
         if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("unexpected reply index %0d status %0d", idx, st));
            return;
         end
         want = pending_replies.pop_front();
         if (st !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", st, want.status));
         if (idx !== want.slot_index)
            report_mismatch($sformatf("slot_index %0d, want %0d", idx, want.slot_index));
      endtask
   endclass

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic [KEY_W-1:0]   req_lookup_key = '0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic [INDEX_W-1:0] rsp_slot_index;
   logic [STATUS_W-1:0] rsp_status;

   slot_lookup_board_type board;
   int unsigned      cycle_count   = 0;
   int unsigned      replies_taken = 0;

   keyed_slot_get_or_create_top #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_lookup_key (req_lookup_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_slot_index (rsp_slot_index),
      .rsp_status     (rsp_status)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** keyed_slot_get_or_create_top: FAILED **");
         $finish;
      end
   end

   function automatic int draw_gap(bit quiet);
      return quiet ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // Hold valid across back-to-back beats; lower it only when a gap follows.
   task automatic send_request(logic [KEY_W-1:0] key, bit quiet);
      int gap;
      gap = draw_gap(quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_lookup_key <= key;
      do @(posedge clock); while (req_stall);
      board.take_request(key);
   endtask

   task automatic take_replies();
      int gap;
      forever begin
         gap = draw_gap(((replies_taken / 40) % 4) == 1);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         board.match_reply(rsp_slot_index, rsp_status);
         replies_taken++;
      end
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      int unsigned      mode;
      int unsigned      slot;
      logic [KEY_W-1:0] key;
      mode = $urandom_range(0, 99);
      slot = $urandom_range(0, TABLE_ENTRIES - 1);
      key  = board.slot_taken[slot] ? board.slot_key[slot] : $urandom();
      if (mode < 55)
         return key;
      // near miss: one bit away from a stored key, or from a random key if the slot is empty
      if (mode < 80)
         return key ^ (32'h1 << $urandom_range(0, KEY_W - 1));
      return $urandom();
   endfunction

   initial begin
      logic [KEY_W-1:0] directed [$];

      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      fork
         take_replies();
      join_none

      // extremes and repeats, then fill the table and run into it being full
      directed = {32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
      for (int k = 0; k < TABLE_ENTRIES - 2; k++)
         directed.push_back(32'h1 << k);
      directed.push_back(32'h8000_0000);
      directed.push_back(32'h0000_2000);
      directed.push_back(32'h0000_0001);
      directed.push_back(32'hFFFF_FFFE);
      directed.push_back(32'h0000_0000);

      foreach (directed[i])
         send_request(directed[i], 1'b0);

      for (int n = 0; n < RANDOM_REQS; n++)
         send_request(pick_key(), ((n / 40) % 4) == 3);
      req_valid <= 1'b0;

      while (board.pending_replies.size() != 0) @(posedge clock);
      repeat (TABLE_ENTRIES + 4) @(posedge clock);

      if (board.mismatches == 0 && board.pending_replies.size() == 0)
         $display("** keyed_slot_get_or_create_top: PASSED **");
      else
         $display("** keyed_slot_get_or_create_top: FAILED **");
      $finish;
   end

endmodule

// File: sim.f
hdl/ksgoc_pkg.sv
hdl/ksgoc_ctrl.sv
hdl/ksgoc_dp.sv
hdl/keyed_slot_get_or_create_top.sv
verif/keyed_slot_get_or_create_top_tb.sv
